>>> src/lifeca_pkg.sv
// shared constants, types and controller/datapath structs for the life grid core
package lifeca_pkg;

  // grid geometry
  localparam int GRID_WIDTH  = 64;
  localparam int GRID_HEIGHT = 32;

  localparam int COL_W  = $clog2(GRID_WIDTH);
  localparam int ROW_W  = $clog2(GRID_HEIGHT);
  // generation sweep runs GRID_HEIGHT + 3 steps
  localparam int STEP_W = $clog2(GRID_HEIGHT + 3);

  // B3/S23 rule counts
  localparam int CNT_W       = 4;
  localparam int BIRTH_COUNT = 3;
  localparam int KEEP_COUNT  = 2;

  // item kinds
  localparam logic [1:0] KIND_SET     = 2'd0;
  localparam logic [1:0] KIND_READ    = 2'd1;
  localparam logic [1:0] KIND_ADVANCE = 2'd2;

  typedef logic [GRID_WIDTH-1:0] grid_row_t;
  typedef logic [COL_W-1:0]      col_idx_t;
  typedef logic [ROW_W-1:0]      row_idx_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load_item;
    logic set_rd;
    logic set_wr;
    logic item_rd;
    logic out_load;
    logic adv_clear;
    logic adv_step;
  } ctrl_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic in_grid;
    logic adv_done;
  } dp_status_t;

endpackage

>>> src/lifeca_ram.sv
// generic simple dual-port ram with registered read
module lifeca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port, holds when idle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> src/lifeca_dp.sv
// datapath: grid memory, row valid bits, coordinate mapping and generation window
module lifeca_dp (
  input  logic                   clk,
  input  logic                   rst_n,
  input  lifeca_pkg::ctrl_cmd_t  cmd,
  output lifeca_pkg::dp_status_t status,
  input  logic                   cfg_wr_en,
  input  logic                   cfg_wr_data,
  input  logic signed [7:0]      in_cell_x,
  input  logic signed [7:0]      in_cell_y,
  input  logic                   in_new_alive,
  output logic                   out_cell_alive
);
  import lifeca_pkg::*;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(GRID_HEIGHT + 2);
  localparam logic [STEP_W-1:0] LAST_RD   = STEP_W'(GRID_HEIGHT);
  localparam logic [STEP_W-1:0] FIRST_WR  = STEP_W'(3);

  // next generation of one row from its old neighbors
  function automatic grid_row_t next_row(input grid_row_t a, input grid_row_t c,
                                         input grid_row_t b, input logic wall);
    logic [GRID_WIDTH+1:0] ea;
    logic [GRID_WIDTH+1:0] ec;
    logic [GRID_WIDTH+1:0] eb;
    logic [CNT_W-1:0]      n;
    grid_row_t             r;
    ea = {(wall ? 1'b0 : a[0]), a, (wall ? 1'b0 : a[GRID_WIDTH-1])};
    ec = {(wall ? 1'b0 : c[0]), c, (wall ? 1'b0 : c[GRID_WIDTH-1])};
    eb = {(wall ? 1'b0 : b[0]), b, (wall ? 1'b0 : b[GRID_WIDTH-1])};
    for (int i = 0; i < GRID_WIDTH; i++) begin
      n = CNT_W'(ea[i]) + CNT_W'(ea[i+1]) + CNT_W'(ea[i+2]) +
          CNT_W'(ec[i]) + CNT_W'(ec[i+2]) +
          CNT_W'(eb[i]) + CNT_W'(eb[i+1]) + CNT_W'(eb[i+2]);
      r[i] = (n == CNT_W'(BIRTH_COUNT)) || (c[i] && (n == CNT_W'(KEEP_COUNT)));
    end
    return r;
  endfunction

  logic                   wall_mode_r;
  logic [GRID_HEIGHT-1:0] row_valid_r;
  logic [STEP_W-1:0]      step_r;
  logic                   rd_valid_r;
  col_idx_t               col_r;
  row_idx_t               row_r;
  logic                   alive_r;
  logic                   in_grid_r;
  logic                   read_hit_r;
  logic                   out_alive_r;
  grid_row_t              above_r;
  grid_row_t              cur_r;
  grid_row_t              row0_r;

  logic      x_neg, x_hi, y_neg, y_hi;
  col_idx_t  col_map;
  row_idx_t  row_map;
  logic      rd_en, wr_en;
  row_idx_t  rd_addr, wr_addr;
  grid_row_t ram_q, rd_eff, below, set_row, wr_data;

  // coordinate range check and wrap mapping
  always_comb begin
    x_neg = in_cell_x[7];
    y_neg = in_cell_y[7];
    x_hi  = !x_neg && ({1'b0, in_cell_x[6:0]} >= 8'(GRID_WIDTH));
    y_hi  = !y_neg && ({1'b0, in_cell_y[6:0]} >= 8'(GRID_HEIGHT));
    if (x_neg) begin
      col_map = COL_W'(GRID_WIDTH - 1);
    end else if (x_hi) begin
      col_map = '0;
    end else begin
      col_map = in_cell_x[COL_W-1:0];
    end
    if (y_neg) begin
      row_map = ROW_W'(GRID_HEIGHT - 1);
    end else if (y_hi) begin
      row_map = '0;
    end else begin
      row_map = in_cell_y[ROW_W-1:0];
    end
  end

  // rows never written read as dead
  assign rd_eff = rd_valid_r ? ram_q : '0;

  // set row: old row with one bit replaced
  always_comb begin
    set_row        = rd_eff;
    set_row[col_r] = alive_r;
  end

  // memory port control
  always_comb begin
    rd_en = cmd.set_rd || cmd.item_rd || (cmd.adv_step && (step_r <= LAST_RD));
    if (cmd.adv_step) begin
      rd_addr = (step_r == '0) ? ROW_W'(GRID_HEIGHT - 1) : ROW_W'(step_r - STEP_W'(1));
    end else begin
      rd_addr = row_r;
    end
    below   = (step_r == LAST_STEP) ? (wall_mode_r ? '0 : row0_r) : rd_eff;
    wr_en   = cmd.set_wr || (cmd.adv_step && (step_r >= FIRST_WR));
    wr_addr = cmd.set_wr ? row_r : ROW_W'(step_r - FIRST_WR);
    wr_data = cmd.set_wr ? set_row : next_row(above_r, cur_r, below, wall_mode_r);
  end

  lifeca_ram #(
    .WIDTH (GRID_WIDTH),
    .DEPTH (GRID_HEIGHT)
  ) u_grid_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  // control registers: mode, row valid bits, sweep step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wall_mode_r <= 1'b1;
      row_valid_r <= '0;
      step_r      <= '0;
    end else begin
      if (cfg_wr_en) begin
        wall_mode_r <= cfg_wr_data;
      end
      if (wr_en) begin
        row_valid_r[wr_addr] <= 1'b1;
      end
      if (cmd.adv_clear) begin
        step_r <= '0;
      end else if (cmd.adv_step && (step_r != LAST_STEP)) begin
        step_r <= step_r + STEP_W'(1);
      end
    end
  end

  // item capture, read valid tag and result word
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      col_r      <= col_map;
      row_r      <= row_map;
      alive_r    <= in_new_alive;
      in_grid_r  <= !(x_neg || x_hi || y_neg || y_hi);
      read_hit_r <= !(x_neg || x_hi || y_neg || y_hi) || !wall_mode_r;
    end
    if (rd_en) begin
      rd_valid_r <= row_valid_r[rd_addr];
    end
    if (cmd.out_load) begin
      out_alive_r <= read_hit_r && rd_eff[col_r];
    end
  end

  // three-row window of the old generation
  always_ff @(posedge clk) begin
    if (cmd.adv_step) begin
      if (step_r == STEP_W'(1)) begin
        cur_r <= wall_mode_r ? '0 : rd_eff;
      end else if ((step_r >= STEP_W'(2)) && (step_r <= STEP_W'(GRID_HEIGHT + 1))) begin
        above_r <= cur_r;
        cur_r   <= rd_eff;
      end
      if (step_r == STEP_W'(2)) begin
        row0_r <= rd_eff;
      end
    end
  end

  assign status.in_grid  = in_grid_r;
  assign status.adv_done = (step_r == LAST_STEP);
  assign out_cell_alive  = out_alive_r;

endmodule

>>> src/lifeca_ctrl.sv
// controller: item sequencing and result word handshake
module lifeca_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             in_kind,
  output logic                   out_valid,
  input  logic                   out_stall,
  output lifeca_pkg::ctrl_cmd_t  cmd,
  input  lifeca_pkg::dp_status_t status
);
  import lifeca_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SET_RD,
    S_SET_WR,
    S_RD_RD,
    S_RD_OUT,
    S_ADV
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          case (in_kind)
            KIND_SET:  state_nxt = S_SET_RD;
            KIND_READ: state_nxt = S_RD_RD;
            KIND_ADVANCE: begin
              cmd.adv_clear = 1'b1;
              state_nxt     = S_ADV;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_SET_RD: begin
        if (status.in_grid) begin
          cmd.set_rd = 1'b1;
          state_nxt  = S_SET_WR;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_SET_WR: begin
        cmd.set_wr = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_RD_RD: begin
        cmd.item_rd = 1'b1;
        state_nxt   = S_RD_OUT;
      end
      S_RD_OUT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_ADV: begin
        cmd.adv_step = 1'b1;
        if (status.adv_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

>>> src/life_cellular_automaton_grid_core.sv
// Conway life grid core (B3/S23) on a GRID_WIDTH x GRID_HEIGHT bit grid held in a
// dual-port RAM, one row per word; a valid bit per row makes the grid read as all
// dead after reset, so there is no clearing pass. One item is worked at a time:
// a set takes its item, reads its row and writes it back (neither when its cell
// is outside the grid), a read reads the row and loads the result register once
// it is free, and an advance sweeps the grid, reading one row per cycle through
// the RAM read port into a three-row window and writing each new row back while
// later old rows are still unread. A result word waits in its own register while
// the next item is taken. The edge mode (wall or wrap) comes from cfg_wr_data; the
// user must write it only while idle, and the block itself does not enforce this.
module life_cellular_automaton_grid_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_kind,
  input  logic signed [7:0] in_cell_x,
  input  logic signed [7:0] in_cell_y,
  input  logic              in_new_alive,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_cell_alive
);
  import lifeca_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  lifeca_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_kind   (in_kind),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  lifeca_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_cell_x      (in_cell_x),
    .in_cell_y      (in_cell_y),
    .in_new_alive   (in_new_alive),
    .out_cell_alive (out_cell_alive)
  );

  // an accepted advance holds off the next word
  a_adv_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_kind == KIND_ADVANCE)) |=> in_stall)
    else $error("advance accepted without busy");

  // set and advance words never raise a result
  a_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !out_valid &&
     ((in_kind == KIND_SET) || (in_kind == KIND_ADVANCE))) |=> !out_valid)
    else $error("result raised by set or advance");

  // a new result appears only while an item is in work
  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without item in work");

endmodule
